[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the iterator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is ignored while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Check that also holds during reset.
`define CHK_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

[hdl/etfi_pkg.sv]
// ----------------------------------------------------------------------------
// etfi_pkg
// Widths, constants and helpers for the escape-time fractal iterator.
// ----------------------------------------------------------------------------
package etfi_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 12;

    // Operand width for the multiplier: holds +/- 2^(FRAC_BITS+1).
    localparam int MUL_W  = FRAC_BITS + 3;
    localparam int PROD_W = 2 * MUL_W;
    // z register width, wide enough that z^2 + k never wraps.
    localparam int Z_W = (COORD_WIDTH + 1 > FRAC_BITS + 5) ? COORD_WIDTH + 1 : FRAC_BITS + 5;

    localparam int CNT_W   = 6;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = (COORD_WIDTH > CNT_W) ? COORD_WIDTH : CNT_W;
    localparam int S_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * CNT_W + 7) / 8) * 8;

    // Escape bounds: |a| or |b| above 2.0, a^2 + b^2 above 4.0.
    localparam logic signed [Z_W-1:0]    LIM2 = Z_W'(1) << (FRAC_BITS + 1);
    localparam logic signed [PROD_W-1:0] LIM4 = PROD_W'(1) << (2 * FRAC_BITS + 2);

    localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd2;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_JRE   = 2'd1,
        REG_JIM   = 2'd2,
        REG_LIMIT = 2'd3
    } cfg_reg_t;

    localparam logic [CNT_W-1:0]        LIMIT_RST = 6'd10;
    localparam logic signed [COORD_WIDTH-1:0] JRE_RST = COORD_WIDTH'(-3277);
    localparam logic signed [COORD_WIDTH-1:0] JIM_RST = COORD_WIDTH'(639);

    // (count*6 + 1) mod 64
    function automatic logic [CNT_W-1:0] palette_of(logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] x4;
        logic [CNT_W-1:0] x2;
        x4 = {cnt[CNT_W-3:0], 2'b00};
        x2 = {cnt[CNT_W-2:0], 1'b0};
        return x4 + x2 + CNT_W'(1);
    endfunction

endpackage

[hdl/escape_time_fractal_iterator_top.sv]
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_top
// Mandelbrot / Julia / burning-ship escape-time iterator on one shared
// multiplier, driven by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload (low bit first)
//  s_*      | in        | point_re[15:0], point_im[31:16]   (request = one point)
//  m_*      | out       | escape_count[5:0], palette_color[11:6], zero pad
//  cfg_*    | in        | write-only: 0 mode, 1 julia re, 2 julia im, 3 limit
//
//  Sequence: load in IDLE, then per iteration SQA, SQB, CROSS and UPD (three
//  passes through the one signed multiplier plus an update step), then DONE.
//  s_tready is high only while the sequencer is idle.
//  The result sits in an output register; a stalled m_tready holds the
//  finished item in DONE but a new request is taken as soon as it moves out.
//  rst_n is asynchronous, active low; state, valid and config registers reset.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // point_re [15:0], point_im [31:16]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [etfi_pkg::S_DATA_W-1:0] s_tdata,
    // escape_count [5:0], palette_color [11:6], zeros above
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [etfi_pkg::M_DATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_addr,
    input  logic [etfi_pkg::CFG_W-1:0]    cfg_data
);
    import etfi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQA,    // limit / magnitude check, a*a
        S_SQB,    // b*b
        S_CROSS,  // escape test on a^2+b^2, a^2-b^2, a*b
        S_UPD,    // z <- z^2 + k
        S_DONE
    } state_t;

    // Configuration registers
    logic [MODE_W-1:0]             mode_reg;
    logic signed [COORD_WIDTH-1:0] jre_reg;
    logic signed [COORD_WIDTH-1:0] jim_reg;
    logic [CNT_W-1:0]              limit_reg;

    // Sequencer and datapath registers
    state_t                        state_reg, state_next;
    logic signed [Z_W-1:0]         za_reg, za_next;
    logic signed [Z_W-1:0]         zb_reg, zb_next;
    logic signed [COORD_WIDTH-1:0] kre_reg, kre_next;
    logic signed [COORD_WIDTH-1:0] kim_reg, kim_next;
    logic                          ship_reg, ship_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [PROD_W-1:0]      a2_reg, a2_next;
    logic signed [PROD_W-1:0]      diff_reg, diff_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0]              out_cnt_reg, out_cnt_next;

    // Shared multiplier
    logic signed [MUL_W-1:0]       mul_x, mul_y;
    logic signed [PROD_W-1:0]      mul_p;

    logic signed [COORD_WIDTH-1:0] in_re, in_im;
    logic signed [PROD_W-1:0]      sq_sum;
    logic signed [PROD_W-1:0]      cross_term;
    logic signed [PROD_W-1:0]      re_shift, im_shift;
    logic                          out_big;

    assign in_re = s_tdata[COORD_WIDTH-1:0];
    assign in_im = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    // Operands are narrowed only after the magnitude check has passed.
    always_comb
    begin
        mul_x = za_reg[MUL_W-1:0];
        mul_y = za_reg[MUL_W-1:0];
        case (state_reg)
            S_SQB:   begin mul_x = zb_reg[MUL_W-1:0]; mul_y = zb_reg[MUL_W-1:0]; end
            S_CROSS: begin mul_x = za_reg[MUL_W-1:0]; mul_y = zb_reg[MUL_W-1:0]; end
            default: ;
        endcase
    end
    assign mul_p = mul_x * mul_y;

    assign out_big = (za_reg > LIM2) || (za_reg < -LIM2) ||
                     (zb_reg > LIM2) || (zb_reg < -LIM2);
    assign sq_sum  = a2_reg + prod_reg;

    // 2ab, mirrored to the positive side for burning ship
    always_comb
    begin
        cross_term = prod_reg <<< 1;
        if (ship_reg && cross_term[PROD_W-1])
            cross_term = -cross_term;
    end
    assign re_shift = diff_reg >>> FRAC_BITS;   // floor division
    assign im_shift = cross_term >>> FRAC_BITS;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        za_next       = za_reg;
        zb_next       = zb_reg;
        kre_next      = kre_reg;
        kim_next      = kim_reg;
        ship_next     = ship_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        a2_next       = a2_reg;
        diff_next     = diff_reg;
        out_cnt_next  = out_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cnt_next  = '0;
                    ship_next = (mode_reg == MODE_SHIP);
                    if (mode_reg == MODE_JULIA)
                    begin
                        za_next  = Z_W'(in_re);
                        zb_next  = Z_W'(in_im);
                        kre_next = jre_reg;
                        kim_next = jim_reg;
                    end
                    else
                    begin
                        za_next  = '0;
                        zb_next  = '0;
                        kre_next = in_re;
                        kim_next = in_im;
                    end
                    state_next = S_SQA;
                end
            end
            S_SQA:
            begin
                if ((cnt_reg >= limit_reg) || out_big)
                    state_next = S_DONE;
                else
                begin
                    prod_next  = mul_p;
                    state_next = S_SQB;
                end
            end
            S_SQB:
            begin
                a2_next    = prod_reg;
                prod_next  = mul_p;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                if (sq_sum > LIM4)
                    state_next = S_DONE;
                else
                begin
                    diff_next  = a2_reg - prod_reg;
                    prod_next  = mul_p;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                za_next    = Z_W'(re_shift) + Z_W'(kre_reg);
                zb_next    = Z_W'(im_shift) + Z_W'(kim_reg);
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_SQA;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_cnt_next  = cnt_reg;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath payload, no reset needed
    always_ff @(posedge clk)
    begin
        za_reg      <= za_next;
        zb_reg      <= zb_next;
        kre_reg     <= kre_next;
        kim_reg     <= kim_next;
        ship_reg    <= ship_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= prod_next;
        a2_reg      <= a2_next;
        diff_reg    <= diff_next;
        out_cnt_reg <= out_cnt_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MANDEL;
            jre_reg   <= JRE_RST;
            jim_reg   <= JIM_RST;
            limit_reg <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                REG_JRE:   jre_reg   <= cfg_data[COORD_WIDTH-1:0];
                REG_JIM:   jim_reg   <= cfg_data[COORD_WIDTH-1:0];
                REG_LIMIT: limit_reg <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - 2*CNT_W){1'b0}}, palette_of(out_cnt_reg), out_cnt_reg};

endmodule

[hdl/etfi_checker.sv]
// ----------------------------------------------------------------------------
// etfi_checker
// Port-level checks for the escape-time fractal iterator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etfi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [etfi_pkg::M_DATA_W-1:0] m_tdata
);
    import etfi_pkg::*;

    logic [CNT_W-1:0] out_count;
    logic [CNT_W-1:0] out_color;

    assign out_count = m_tdata[CNT_W-1:0];
    assign out_color = m_tdata[2*CNT_W-1:CNT_W];

    // palette always tracks the count it is shown with
    `CHK_ASSERT(a_palette, clk, rst_n, m_tvalid |-> (out_color == palette_of(out_count)))

    // one point at a time: input closes right after a request
    `CHK_ASSERT(a_busy_after_req, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready)

    // stalled result holds
    `CHK_ASSERT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // no stale result out of reset
    `CHK_ASSERT_NR(a_reset_clear, clk, (!rst_n) |-> !m_tvalid)

endmodule

bind escape_time_fractal_iterator_top etfi_checker u_etfi_checker (.*);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape-time fractal iterator. Points go in on
// the s_* stream and escape results come back on m_*. Each accepted point is
// run through a local iteration model under the current register settings,
// and every returned result is checked against the oldest prediction.
// Directed corner points come first, then random phases with fresh register
// settings, with random sender gaps and receiver stalls switched per phase.
// ----------------------------------------------------------------------------
module tb_top;

    import etfi_pkg::*;

    // escape tests in Q-scaled integers: |a| or |b| above 2.0, a^2+b^2 above 4.0
    localparam longint ESC_RADIUS    = longint'(2) <<< FRAC_BITS;
    localparam longint ESC_RADIUS_SQ = longint'(4) <<< (2 * FRAC_BITS);
    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     RAND_PHASES   = 8;
    localparam int     PHASE_POINTS  = 100;
    localparam int     MAX_REPORTS   = 50;

    // tdata layout, high field first
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] im;
        logic signed [COORD_WIDTH-1:0] re;
    } point_t;

    typedef struct packed {
        logic [CNT_W-1:0] color;
        logic [CNT_W-1:0] count;
    } escape_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we;
    logic [1:0]           cfg_addr;
    logic [CFG_W-1:0]     cfg_data;

    // shadow copy of the block's registers
    logic [MODE_W-1:0]             mode_cfg;
    logic signed [COORD_WIDTH-1:0] jre_cfg;
    logic signed [COORD_WIDTH-1:0] jim_cfg;
    logic [CNT_W-1:0]              limit_cfg;

    point_t  pending_points[$];
    escape_t escape_expected[$];

    logic point_taken;
    logic result_taken;
    bit   send_gaps_on;
    bit   recv_stalls_on;
    int   send_gap;
    int   stall_left;
    int   cycle_count;
    int   mismatch_count;

    escape_time_fractal_iterator_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Escape-time count for one point under the shadow registers.
    // Arithmetic right shift on longint floors, as the block does.
    function automatic escape_t predict_escape(point_t p);
        longint  a;
        longint  b;
        longint  kre;
        longint  kim;
        longint  a2;
        longint  b2;
        longint  cross_term;
        int      n;
        escape_t r;
        if (mode_cfg == MODE_JULIA)
        begin
            a   = longint'(p.re);
            b   = longint'(p.im);
            kre = longint'(jre_cfg);
            kim = longint'(jim_cfg);
        end
        else
        begin
            // mandelbrot, burning ship and the spare mode code
            a   = 0;
            b   = 0;
            kre = longint'(p.re);
            kim = longint'(p.im);
        end
        n = 0;
        while (n < limit_cfg)
        begin
            if (a > ESC_RADIUS || -a > ESC_RADIUS || b > ESC_RADIUS || -b > ESC_RADIUS)
                break;
            a2 = a * a;
            b2 = b * b;
            if (a2 + b2 > ESC_RADIUS_SQ)
                break;
            cross_term = 2 * a * b;
            if (mode_cfg == MODE_SHIP && cross_term < 0)
                cross_term = -cross_term;
            a = ((a2 - b2) >>> FRAC_BITS) + kre;
            b = (cross_term >>> FRAC_BITS) + kim;
            n++;
        end
        r.count = CNT_W'(n);
        r.color = CNT_W'(n * 6 + 1);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    // One register write; the shadow copy follows after the write edge.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_MODE:  mode_cfg  = value[MODE_W-1:0];
            REG_JRE:   jre_cfg   = value[COORD_WIDTH-1:0];
            REG_JIM:   jim_cfg   = value[COORD_WIDTH-1:0];
            REG_LIMIT: limit_cfg = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_point(int re, int im);
        point_t p;
        p.re = COORD_WIDTH'(re);
        p.im = COORD_WIDTH'(im);
        pending_points.push_back(p);
    endtask

    // Idle = nothing queued, nothing on the request side, nothing outstanding.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_points.size() != 0 || s_tvalid || escape_expected.size() != 0);
    endtask

    // Request driver: one point per request, random gap after each while gaps are on.
    // Valid stays high across back-to-back requests.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || point_taken))
        begin
            if (send_gap == 0 && pending_points.size() != 0)
            begin
                s_tdata  <= S_DATA_W'(pending_points.pop_front());
                s_tvalid <= 1'b1;
                send_gap = send_gaps_on ? $urandom_range(0, 19) : 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (send_gap != 0)
                    send_gap--;
            end
        end
    end

    // Receiver back-pressure, free running so stalls land on any phase.
    always @(negedge clk)
    begin
        if (result_taken)
            stall_left = recv_stalls_on ? $urandom_range(0, 19) : 0;
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor: predict on each accepted point, check each accepted result.
    always @(posedge clk)
    begin
        escape_t want;
        escape_t got;
        point_taken  <= s_tvalid && s_tready;
        result_taken <= m_tvalid && m_tready;
        cycle_count++;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                escape_expected.push_back(predict_escape(point_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                got = escape_t'(m_tdata[2*CNT_W-1:0]);
                if (escape_expected.size() == 0)
                    report_mismatch($sformatf("result with no point pending: count %0d",
                                              got.count));
                else
                begin
                    want = escape_expected.pop_front();
                    if (got.count != want.count)
                        report_mismatch($sformatf("escape_count got %0d want %0d",
                                                  got.count, want.count));
                    if (got.color != want.color)
                        report_mismatch($sformatf("palette_color got %0d want %0d",
                                                  got.color, want.color));
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] word;
        int               lim;
        int               pace;
        int               re;
        int               im;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_MODE;
        cfg_data       = '0;
        point_taken    = 1'b0;
        result_taken   = 1'b0;
        send_gap       = 0;
        stall_left     = 0;
        cycle_count    = 0;
        mismatch_count = 0;
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        // registers come up at their defaults
        mode_cfg  = MODE_MANDEL;
        jre_cfg   = JRE_RST;
        jim_cfg   = JIM_RST;
        limit_cfg = LIMIT_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed: mandelbrot at reset settings
        send_point(0, 0);                  // origin never escapes
        send_point(-32768, -32768);        // field extremes
        send_point(32767, 32767);
        send_point(-32768, 32767);
        send_point(8192, 0);               // exactly 2.0: |z|^2 == 4 is not an escape
        send_point(8193, 0);               // just past 2.0
        send_point(0, -8192);
        send_point(-8192, 0);
        send_point(-4096, 0);              // orbit alternates between 0 and -1.0, stays inside
        send_point(-1, -1);                // floor rounding on tiny negatives
        send_point(1229, 2458);
        send_point(-6144, 4096);
        wait_idle();

        // julia with the reset constants
        write_reg(REG_MODE, CFG_W'(MODE_JULIA));
        send_point(0, 0);
        send_point(8192, 8192);            // starts outside radius, zero iterations
        send_point(-32768, 0);
        send_point(1000, -500);
        wait_idle();

        // burning ship; upper bits of the mode word are ignored
        write_reg(REG_MODE, 16'hABCE);
        send_point(-7000, -2000);
        send_point(1024, -4096);
        send_point(-32768, 32767);
        wait_idle();

        // spare mode code acts as mandelbrot; a zero limit runs no iteration
        write_reg(REG_MODE, 16'hFFFF);
        write_reg(REG_LIMIT, 16'h0FC0);
        send_point(0, 0);
        send_point(-4096, 100);
        wait_idle();
        write_reg(REG_LIMIT, 16'hFFFF);    // 63
        send_point(0, 0);
        send_point(-32768, -1);
        wait_idle();

        // --- random phases, fresh registers each time
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            pace = (ph == 2) ? 0 : (ph == 3) ? 3 : $urandom_range(0, 3);
            send_gaps_on   = pace[0];
            recv_stalls_on = pace[1];

            word = CFG_W'($urandom);
            if (ph == 0)
                word[MODE_W-1:0] = MODE_JULIA;
            else if (ph == 1)
                word[MODE_W-1:0] = MODE_SHIP;
            write_reg(REG_MODE, word);

            if (ph == 0)
            begin
                write_reg(REG_JRE, 16'h8000);
                write_reg(REG_JIM, 16'h7FFF);
            end
            else if (ph == 1)
            begin
                write_reg(REG_JRE, 16'h7FFF);
                write_reg(REG_JIM, 16'h8000);
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                // constants near the interesting part of the plane
                write_reg(REG_JRE, CFG_W'(int'($urandom_range(0, 8192)) - 4096));
                write_reg(REG_JIM, CFG_W'(int'($urandom_range(0, 8192)) - 4096));
            end
            else
            begin
                write_reg(REG_JRE, CFG_W'($urandom));
                write_reg(REG_JIM, CFG_W'($urandom));
            end

            case ($urandom_range(0, 5))
                0:       lim = 0;
                1:       lim = 1;
                2:       lim = 63;
                default: lim = $urandom_range(1, 63);
            endcase
            if (ph == 0)
                lim = 63;
            else if (ph == 1)
                lim = 1;
            word = CFG_W'($urandom);
            word[CNT_W-1:0] = CNT_W'(lim);
            write_reg(REG_LIMIT, word);

            for (int i = 0; i < PHASE_POINTS; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        // anywhere in the field range
                        re = int'($urandom_range(0, 65535)) - 32768;
                        im = int'($urandom_range(0, 65535)) - 32768;
                    end
                    2:
                    begin
                        // hugging the radius-2 circle on an axis
                        re = ($urandom_range(0, 1) ? 8192 : -8192)
                             + int'($urandom_range(0, 8)) - 4;
                        im = int'($urandom_range(0, 8)) - 4;
                    end
                    default:
                    begin
                        // window around the sets, where escape times vary
                        re = int'($urandom_range(0, 18432)) - 10240;
                        im = int'($urandom_range(0, 16384)) - 8192;
                    end
                endcase
                send_point(re, im);
            end
            wait_idle();
        end

        // let any stray result show up before closing
        repeat (4 * 63 + 40) @(posedge clk);
        if (escape_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", escape_expected.size()));

        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/etfi_pkg.sv
hdl/escape_time_fractal_iterator_top.sv
hdl/etfi_checker.sv
test/tb_top.sv
